FILE: sv/alurf_pkg.sv
// ----------------------------------------------------------------------------
// alurf_pkg
// Shared types, command codes and constants for the register-file ALU.
// ----------------------------------------------------------------------------
package alurf_pkg;

  localparam int WORD_W    = 16;
  localparam int REG_COUNT = 16;
  localparam int IDX_W     = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  // Upper bound for a 4-bit register field, one bit wider to hold the count
  localparam logic [4:0] REG_LIMIT = 5'(REG_COUNT);

  localparam logic [WORD_W-1:0] WORD_ONES = 16'hFFFF;
  localparam logic [WORD_W-1:0] WORD_SMAX = 16'h7FFF;
  localparam logic [WORD_W-1:0] WORD_SMIN = 16'h8000;

  typedef enum logic [3:0] {
    CMD_LOAD   = 4'd0,
    CMD_READ   = 4'd1,
    CMD_ADD    = 4'd2,
    CMD_SUB    = 4'd3,
    CMD_NOT    = 4'd4,
    CMD_AND    = 4'd5,
    CMD_OR     = 4'd6,
    CMD_XOR    = 4'd7,
    CMD_INC    = 4'd8,
    CMD_DEC    = 4'd9,
    CMD_LSHIFT = 4'd10,
    CMD_RSHIFT = 4'd11
  } cmd_e;

  typedef struct packed {
    logic [3:0]        command;
    logic [3:0]        dest;
    logic [3:0]        src;
    logic [WORD_W-1:0] load_value;
  } in_t;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic              zero_flag;
    logic              carry_flag;
    logic              negative_flag;
    logic              overflow_flag;
  } out_t;

  typedef struct packed {
    logic z;
    logic c;
    logic n;
    logic v;
  } flags_t;

  // ALU outcome for one beat: register write, reported value, new flags
  typedef struct packed {
    logic              wr_en;
    logic [WORD_W-1:0] value;
    flags_t            flags;
  } alu_res_t;

endpackage

FILE: sv/alurf_regfile.sv
// ----------------------------------------------------------------------------
// alurf_regfile
// Register file with one write port and two registered read ports. Reads
// see a write at the same edge. Entries read as zero until first written.
// ----------------------------------------------------------------------------
module alurf_regfile (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 we,
  input  logic [alurf_pkg::IDX_W-1:0]          waddr,
  input  logic [alurf_pkg::WORD_W-1:0]         wdata,
  input  logic                                 re,
  input  logic [alurf_pkg::IDX_W-1:0]          raddr_a,
  input  logic [alurf_pkg::IDX_W-1:0]          raddr_b,
  output logic [alurf_pkg::WORD_W-1:0]         rdata_a,
  output logic [alurf_pkg::WORD_W-1:0]         rdata_b
);

  logic [alurf_pkg::WORD_W-1:0]    mem [alurf_pkg::REG_COUNT];
  logic [alurf_pkg::REG_COUNT-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Forward the write data on an address match, else zero for unwritten entries
  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (waddr == raddr_a)) rdata_a <= wdata;
      else if (vld[raddr_a])        rdata_a <= mem[raddr_a];
      else                          rdata_a <= '0;
      if (we && (waddr == raddr_b)) rdata_b <= wdata;
      else if (vld[raddr_b])        rdata_b <= mem[raddr_b];
      else                          rdata_b <= '0;
    end
  end

endmodule

FILE: sv/alurf_alu.sv
// ----------------------------------------------------------------------------
// alurf_alu
// Combinational ALU: computes the result word, the write enable and the
// new flags for one command.
// ----------------------------------------------------------------------------
module alurf_alu (
  input  logic [3:0]                   command,
  input  logic                         d_ok,
  input  logic                         s_ok,
  input  logic [alurf_pkg::WORD_W-1:0] a,
  input  logic [alurf_pkg::WORD_W-1:0] b,
  input  logic [alurf_pkg::WORD_W-1:0] load_value,
  input  alurf_pkg::flags_t            flags_in,
  output alurf_pkg::alu_res_t          res
);

  logic                         two_op;
  logic                         ok;
  logic [alurf_pkg::WORD_W:0]   add_u;
  logic [alurf_pkg::WORD_W:0]   add_s;
  logic [alurf_pkg::WORD_W-1:0] neg_b;
  logic [alurf_pkg::WORD_W:0]   sub_u;
  logic [alurf_pkg::WORD_W:0]   sub_s;
  logic [alurf_pkg::WORD_W-1:0] word;

  assign two_op = command inside {alurf_pkg::CMD_ADD, alurf_pkg::CMD_SUB,
                                  alurf_pkg::CMD_AND, alurf_pkg::CMD_OR,
                                  alurf_pkg::CMD_XOR};
  assign ok     = d_ok && !(two_op && !s_ok);

  assign add_u = {1'b0, a} + {1'b0, b};
  assign add_s = {a[15], a} + {b[15], b};
  assign neg_b = 16'(~b + 16'd1);
  assign sub_u = {1'b0, a} + {1'b0, neg_b};
  assign sub_s = {a[15], a} - {b[15], b};

  always_comb begin
    word      = a;
    res.wr_en = 1'b0;
    res.flags = flags_in;
    case (command)
      alurf_pkg::CMD_LOAD: begin
        word      = load_value;
        res.wr_en = 1'b1;
      end
      alurf_pkg::CMD_ADD: begin
        word        = add_u[15:0];
        res.wr_en   = 1'b1;
        res.flags.z = (word == '0);
        res.flags.c = add_u[16];
        res.flags.n = add_s[16];
        res.flags.v = (a[15] == b[15]) && (word[15] != a[15]);
      end
      alurf_pkg::CMD_SUB: begin
        word        = sub_s[15:0];
        res.wr_en   = 1'b1;
        res.flags.z = (word == '0);
        res.flags.c = sub_u[16];
        res.flags.n = sub_s[16];
        res.flags.v = (a[15] != b[15]) && (word[15] != a[15]);
      end
      alurf_pkg::CMD_NOT, alurf_pkg::CMD_AND, alurf_pkg::CMD_OR,
      alurf_pkg::CMD_XOR, alurf_pkg::CMD_RSHIFT: begin
        case (command)
          alurf_pkg::CMD_NOT: word = ~a;
          alurf_pkg::CMD_AND: word = a & b;
          alurf_pkg::CMD_OR:  word = a | b;
          alurf_pkg::CMD_XOR: word = a ^ b;
          default:            word = {1'b0, a[15:1]};
        endcase
        res.wr_en   = 1'b1;
        res.flags.z = (word == '0);
        res.flags.c = 1'b0;
        res.flags.n = word[15];
        res.flags.v = 1'b0;
      end
      alurf_pkg::CMD_INC: begin
        word        = 16'(a + 16'd1);
        res.wr_en   = 1'b1;
        res.flags.z = (word == '0);
        res.flags.c = (a == alurf_pkg::WORD_ONES);
        res.flags.n = word[15];
        res.flags.v = (a == alurf_pkg::WORD_SMAX);
      end
      alurf_pkg::CMD_DEC: begin
        word        = 16'(a + alurf_pkg::WORD_ONES);
        res.wr_en   = 1'b1;
        res.flags.z = (word == '0);
        res.flags.c = 1'b1;
        res.flags.n = word[15];
        res.flags.v = (a == alurf_pkg::WORD_SMIN);
      end
      alurf_pkg::CMD_LSHIFT: begin
        word        = {a[14:0], 1'b0};
        res.wr_en   = 1'b1;
        res.flags.z = (word == '0);
        res.flags.c = a[15];
        res.flags.n = word[15];
        res.flags.v = 1'b0;
      end
      default: begin
        // read, and unused codes behave as read
        word = a;
      end
    endcase

    // Drop the command entirely when a named register is out of range
    if (!ok) begin
      word      = '0;
      res.wr_en = 1'b0;
      res.flags = flags_in;
    end
    res.value = word;
  end

endmodule

FILE: sv/alu_register_file_with_flags.sv
// A command beat passes through the operand stage and then the result register before its result shows on res.
// Throughput: one command per cycle, sustained, while res is taken.
// The register file write and the flag update both happen on the edge that
// moves a command from the operand stage into the result register.
// Reset (rst, synchronous): all registers and flags read as zero in the next
// cycle; the register file clears through per-entry valid bits.
// ----------------------------------------------------------------------------
// alu_register_file_with_flags
// Register-file ALU with Z/C/N/V flags: operand stage, ALU, result register.
// ----------------------------------------------------------------------------
module alu_register_file_with_flags (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  alurf_pkg::in_t  cmd,
  output logic            res_valid,
  input  logic            res_ready,
  output alurf_pkg::out_t res
);

  // Operand stage: holds the command whose register reads are in flight
  logic                         st_valid;
  alurf_pkg::in_t               st_cmd;
  logic [alurf_pkg::WORD_W-1:0] op_a;
  logic [alurf_pkg::WORD_W-1:0] op_b;

  alurf_pkg::flags_t   flags;
  alurf_pkg::alu_res_t alu_res;

  logic cmd_fire;
  logic advance;
  logic d_ok;
  logic s_ok;

  // Advance the operand stage whenever the result register is free or drains
  assign advance   = st_valid && (!res_valid || res_ready);
  assign cmd_ready = !st_valid || advance;
  assign cmd_fire  = cmd_valid && cmd_ready;

  assign d_ok = ({1'b0, st_cmd.dest} < alurf_pkg::REG_LIMIT);
  assign s_ok = ({1'b0, st_cmd.src}  < alurf_pkg::REG_LIMIT);

  // Read both operands on the accepting edge; a write retiring on that same
  // edge is forwarded inside the register file
  alurf_regfile u_regfile (
    .clk     (clk),
    .rst     (rst),
    .we      (advance && alu_res.wr_en),
    .waddr   (st_cmd.dest[alurf_pkg::IDX_W-1:0]),
    .wdata   (alu_res.value),
    .re      (cmd_fire),
    .raddr_a (cmd.dest[alurf_pkg::IDX_W-1:0]),
    .raddr_b (cmd.src[alurf_pkg::IDX_W-1:0]),
    .rdata_a (op_a),
    .rdata_b (op_b)
  );

  alurf_alu u_alu (
    .command    (st_cmd.command),
    .d_ok       (d_ok),
    .s_ok       (s_ok),
    .a          (op_a),
    .b          (op_b),
    .load_value (st_cmd.load_value),
    .flags_in   (flags),
    .res        (alu_res)
  );

  // Operand stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (cmd_fire) begin
      st_valid <= 1'b1;
    end else if (advance) begin
      st_valid <= 1'b0;
    end
  end

  // Capture the command beat; no reset needed on payload
  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      st_cmd <= cmd;
    end
  end

  // Flags: commit the ALU's view on each retiring command
  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (advance) begin
      flags <= alu_res.flags;
    end
  end

  // Result register: load on advance, drop valid once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res.value         <= alu_res.value;
      res.zero_flag     <= alu_res.flags.z;
      res.carry_flag    <= alu_res.flags.c;
      res.negative_flag <= alu_res.flags.n;
      res.overflow_flag <= alu_res.flags.v;
    end
  end

endmodule

FILE: sv/alurf_checker.sv
// ----------------------------------------------------------------------------
// alurf_checker
// Port-level checks for the register-file ALU, bound to the top level.
// ----------------------------------------------------------------------------
module alurf_checker (
  input logic            clk,
  input logic            rst,
  input logic            cmd_valid,
  input logic            cmd_ready,
  input logic            res_valid,
  input logic            res_ready,
  input alurf_pkg::out_t res
);

  // Commands accepted but whose result beat is not yet taken
  logic [1:0] pending;
  logic       in_beat;
  logic       out_beat;

  assign in_beat  = cmd_valid && cmd_ready;
  assign out_beat = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_beat && !out_beat) begin
      pending <= 2'(pending + 2'd1);
    end else if (out_beat && !in_beat) begin
      pending <= 2'(pending - 2'd1);
    end
  end

  // A stalled result holds its payload
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  // Input back-pressure only when the result side is stalled
  a_bp_cause: assert property (@(posedge clk) disable iff (rst)
    !cmd_ready |-> res_valid && !res_ready)
    else $error("command stalled without a stalled result");

  // No result without a command behind it
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> pending != 2'd0)
    else $error("result with no outstanding command");

  // At most two commands in flight: operand stage and result register
  a_depth: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more than two commands in flight");

endmodule

bind alu_register_file_with_flags alurf_checker u_checker (.*);

FILE: sim/tb_alu_register_file_with_flags.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_alu_register_file_with_flags
// Self-checking bench for the register-file ALU. A directed table opens the
// run and random command beats follow. Each beat passes through a local model
// of the register file and flags, and each result is checked against it or a typed result.
// ----------------------------------------------------------------------------
module tb_alu_register_file_with_flags;

  // Command codes above the last defined one; the block treats them as read
  localparam logic [3:0] CMD_SPARE_LO = 4'd12;
  localparam logic [3:0] CMD_SPARE_HI = 4'd15;

  // Register file indexes named in the directed table
  localparam logic [3:0] R0 = 4'd0, R1 = 4'd1, R2 = 4'd2, R3 = 4'd3, R4 = 4'd4,
                         R5 = 4'd5, R6 = 4'd6, R7 = 4'd7, R8 = 4'd8, R15 = 4'd15;

  localparam int MSB          = alurf_pkg::WORD_W - 1;
  localparam int RANDOM_BEATS = 1850;
  localparam int TAIL_CYCLES  = 8;     // watch for stray results after the drain

  // Directed table row: the command beat, plus a typed result where one is given
  typedef struct packed {
    alurf_pkg::in_t  beat;
    logic            fixed;
    alurf_pkg::out_t want;
  } cmd_row_t;

  typedef enum {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_PERIODIC} ready_mode_e;

  logic            clk;
  logic            rst;
  logic            cmd_valid;
  logic            cmd_ready;
  alurf_pkg::in_t  cmd;
  logic            res_valid;
  logic            res_ready;
  alurf_pkg::out_t res;

  // Local copy of the architectural state
  logic [alurf_pkg::WORD_W-1:0] regfile_model [alurf_pkg::REG_COUNT];
  alurf_pkg::flags_t            flags_model;

  alurf_pkg::out_t expected_res_q [$];
  cmd_row_t        directed_tbl [$];

  int mismatch_count;
  int results_checked;
  int burst_left;

  alu_register_file_with_flags dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs or loses a beat
  initial begin
    #2_000_000;
    $display("alu_register_file_with_flags test failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Model: apply one command to the local register file and flags, and return
  // the result the block must report for it.
  // --------------------------------------------------------------------------
  function automatic alurf_pkg::out_t alu_predict(alurf_pkg::in_t b);
    logic [alurf_pkg::WORD_W-1:0] a;
    logic [alurf_pkg::WORD_W-1:0] s;
    logic [alurf_pkg::WORD_W-1:0] neg_s;
    logic [alurf_pkg::WORD_W-1:0] r;
    logic [alurf_pkg::WORD_W:0]   wide;
    logic [alurf_pkg::WORD_W:0]   exact;
    alurf_pkg::out_t              o;
    a = regfile_model[b.dest];
    s = regfile_model[b.src];
    case (b.command)
      alurf_pkg::CMD_LOAD: regfile_model[b.dest] = b.load_value;
      alurf_pkg::CMD_ADD: begin
        wide  = {1'b0, a} + {1'b0, s};
        exact = {a[MSB], a} + {s[MSB], s};
        r = wide[MSB:0];
        regfile_model[b.dest] = r;
        flags_model.z = (r == '0);
        flags_model.c = wide[alurf_pkg::WORD_W];
        // N follows the sign of the unwrapped sum, not the stored word
        flags_model.n = exact[alurf_pkg::WORD_W];
        flags_model.v = (a[MSB] == s[MSB]) && (r[MSB] != a[MSB]);
      end
      alurf_pkg::CMD_SUB: begin
        // Carry comes from d plus the two's complement of s, so s of zero clears it
        neg_s = ~s + 16'd1;
        wide  = {1'b0, a} + {1'b0, neg_s};
        exact = {a[MSB], a} - {s[MSB], s};
        r = a - s;
        regfile_model[b.dest] = r;
        flags_model.z = (r == '0);
        flags_model.c = wide[alurf_pkg::WORD_W];
        flags_model.n = exact[alurf_pkg::WORD_W];
        flags_model.v = (a[MSB] != s[MSB]) && (r[MSB] != a[MSB]);
      end
      alurf_pkg::CMD_NOT, alurf_pkg::CMD_AND, alurf_pkg::CMD_OR,
      alurf_pkg::CMD_XOR, alurf_pkg::CMD_RSHIFT: begin
        case (b.command)
          alurf_pkg::CMD_NOT: r = ~a;
          alurf_pkg::CMD_AND: r = a & s;
          alurf_pkg::CMD_OR:  r = a | s;
          alurf_pkg::CMD_XOR: r = a ^ s;
          default:            r = a >> 1;
        endcase
        regfile_model[b.dest] = r;
        flags_model = '{z: (r == '0), c: 1'b0, n: r[MSB], v: 1'b0};
      end
      alurf_pkg::CMD_INC: begin
        r = a + 16'd1;
        regfile_model[b.dest] = r;
        flags_model = '{z: (r == '0), c: (a == alurf_pkg::WORD_ONES), n: r[MSB],
                        v: (a == alurf_pkg::WORD_SMAX)};
      end
      alurf_pkg::CMD_DEC: begin
        r = a - 16'd1;
        regfile_model[b.dest] = r;
        flags_model = '{z: (r == '0), c: 1'b1, n: r[MSB],
                        v: (a == alurf_pkg::WORD_SMIN)};
      end
      alurf_pkg::CMD_LSHIFT: begin
        r = a << 1;
        regfile_model[b.dest] = r;
        flags_model = '{z: (r == '0), c: a[MSB], n: r[MSB], v: 1'b0};
      end
      default: ;  // read and the spare codes change nothing
    endcase
    o.value = regfile_model[b.dest];
    {o.zero_flag, o.carry_flag, o.negative_flag, o.overflow_flag} = flags_model;
    return o;
  endfunction

  // Append one row to the directed table
  function automatic void add_row(logic [3:0] c, logic [3:0] d, logic [3:0] s,
                                  logic [15:0] w, logic fix, logic [15:0] val,
                                  logic [3:0] zcnv);
    cmd_row_t t;
    t.beat  = '{command: c, dest: d, src: s, load_value: w};
    t.fixed = fix;
    t.want.value = val;
    {t.want.zero_flag, t.want.carry_flag, t.want.negative_flag,
     t.want.overflow_flag} = zcnv;
    directed_tbl.insert(directed_tbl.size(), t);
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    mismatch_count++;
    $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
  endtask

  // Insert a random idle gap between bursts; scramble the payload while idle
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        cmd_valid <= 1'b0;
        cmd       <= alurf_pkg::in_t'($bits(alurf_pkg::in_t)'($urandom));
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
  endtask

  // Present one beat, hold it until accepted, then log its expected result
  task automatic send_beat(alurf_pkg::in_t b, logic fix, alurf_pkg::out_t want);
    alurf_pkg::out_t pred;
    @(negedge clk);
    cmd_valid <= 1'b1;
    cmd       <= b;
    do @(posedge clk); while (!cmd_ready);
    pred = alu_predict(b);
    expected_res_q.insert(expected_res_q.size(), fix ? want : pred);
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 9))
      0: return alurf_pkg::WORD_ONES;
      1: return alurf_pkg::WORD_SMAX;
      2: return alurf_pkg::WORD_SMIN;
      3: return 16'h0000;
      4: return 16'h0001;
      5: return 16'h8001;
      default: return 16'($urandom);
    endcase
  endfunction

  // Favor the low four registers half the time so results feed back quickly
  function automatic logic [3:0] pick_reg();
    if ($urandom_range(0, 1) == 0) return 4'($urandom_range(0, 3));
    return 4'($urandom_range(0, alurf_pkg::REG_COUNT - 1));
  endfunction

  function automatic logic [3:0] pick_cmd();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 18) return alurf_pkg::CMD_LOAD;
    if (roll < 22) return alurf_pkg::CMD_READ;
    if (roll < 25) return 4'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    return 4'($urandom_range(alurf_pkg::CMD_ADD, alurf_pkg::CMD_RSHIFT));
  endfunction

  // --------------------------------------------------------------------------
  // Result side: pace res_ready with a pattern chosen anew for each segment of random length.
  // --------------------------------------------------------------------------
  initial begin : res_pacer
    ready_mode_e mode;
    int          seg;
    int          k;
    res_ready = 1'b0;
    forever begin
      mode = ready_mode_e'($urandom_range(0, 3));
      seg  = $urandom_range(8, 96);
      for (k = 0; k < seg; k++) begin
        @(negedge clk);
        case (mode)
          RDY_ALWAYS: res_ready <= 1'b1;
          RDY_COIN:   res_ready <= 1'($urandom_range(0, 1));
          RDY_SPARSE: res_ready <= ($urandom_range(0, 3) == 0);
          default:    res_ready <= ((k % 7) >= 3);
        endcase
      end
    end
  end

  // Check every result beat against the oldest outstanding expectation
  always @(posedge clk) begin
    alurf_pkg::out_t want;
    if (!rst && res_valid && res_ready) begin
      if (expected_res_q.size() == 0) begin
        report_mismatch("result beat with nothing outstanding", res.value, 16'h0000);
      end else begin
        want = expected_res_q.pop_front();
        results_checked++;
        if (res.value !== want.value)
          report_mismatch("value", res.value, want.value);
        if (res.zero_flag !== want.zero_flag)
          report_mismatch("Z flag", 16'(res.zero_flag), 16'(want.zero_flag));
        if (res.carry_flag !== want.carry_flag)
          report_mismatch("C flag", 16'(res.carry_flag), 16'(want.carry_flag));
        if (res.negative_flag !== want.negative_flag)
          report_mismatch("N flag", 16'(res.negative_flag), 16'(want.negative_flag));
        if (res.overflow_flag !== want.overflow_flag)
          report_mismatch("V flag", 16'(res.overflow_flag), 16'(want.overflow_flag));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence: reset, directed table, random beats, drain, verdict.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    alurf_pkg::in_t b;
    int             i;
    rst             = 1'b1;
    cmd_valid       = 1'b0;
    cmd             = '0;
    mismatch_count  = 0;
    results_checked = 0;
    burst_left      = 0;
    for (i = 0; i < alurf_pkg::REG_COUNT; i++) regfile_model[i] = '0;
    flags_model = '0;

    // Directed table. Typed results cover reset state and the inc/dec extremes;
    // the other rows rely on the model. Flag column order is Z C N V.
    add_row(alurf_pkg::CMD_READ,   R0,  R0, 16'h0000, 1'b1, 16'h0000, 4'b0000);
    add_row(alurf_pkg::CMD_READ,   R15, R0, 16'h0000, 1'b1, 16'h0000, 4'b0000);
    add_row(alurf_pkg::CMD_LOAD,   R1,  R0, 16'hFFFF, 1'b1, 16'hFFFF, 4'b0000);
    add_row(alurf_pkg::CMD_INC,    R1,  R0, 16'h0000, 1'b1, 16'h0000, 4'b1100);
    // Load leaves the flags from the increment in place
    add_row(alurf_pkg::CMD_LOAD,   R2,  R0, 16'h7FFF, 1'b1, 16'h7FFF, 4'b1100);
    add_row(alurf_pkg::CMD_INC,    R2,  R0, 16'h0000, 1'b1, 16'h8000, 4'b0011);
    add_row(alurf_pkg::CMD_DEC,    R2,  R0, 16'h0000, 1'b1, 16'h7FFF, 4'b0101);
    add_row(alurf_pkg::CMD_DEC,    R0,  R0, 16'h0000, 1'b1, 16'hFFFF, 4'b0110);
    add_row(alurf_pkg::CMD_LOAD,   R3,  R0, 16'h8000, 1'b0, 16'h0000, 4'b0000);
    // Most negative plus itself: wraps to zero, sign of the exact sum is set
    add_row(alurf_pkg::CMD_ADD,    R3,  R3, 16'h0000, 1'b0, 16'h0000, 4'b0000);
    add_row(alurf_pkg::CMD_LOAD,   R4,  R0, 16'h0001, 1'b0, 16'h0000, 4'b0000);
    // Subtract zero: carry must come out clear
    add_row(alurf_pkg::CMD_SUB,    R4,  R5, 16'h0000, 1'b0, 16'h0000, 4'b0000);
    add_row(alurf_pkg::CMD_SUB,    R0,  R0, 16'h0000, 1'b0, 16'h0000, 4'b0000);
    add_row(alurf_pkg::CMD_LOAD,   R5,  R0, 16'h7FFF, 1'b0, 16'h0000, 4'b0000);
    add_row(alurf_pkg::CMD_ADD,    R5,  R4, 16'h0000, 1'b0, 16'h0000, 4'b0000);
    add_row(alurf_pkg::CMD_SUB,    R3,  R4, 16'h0000, 1'b0, 16'h0000, 4'b0000);
    add_row(alurf_pkg::CMD_NOT,    R6,  R0, 16'h0000, 1'b0, 16'h0000, 4'b0000);
    add_row(alurf_pkg::CMD_AND,    R6,  R5, 16'h0000, 1'b0, 16'h0000, 4'b0000);
    add_row(alurf_pkg::CMD_OR,     R7,  R5, 16'h0000, 1'b0, 16'h0000, 4'b0000);
    add_row(alurf_pkg::CMD_XOR,    R6,  R6, 16'h0000, 1'b0, 16'h0000, 4'b0000);
    add_row(alurf_pkg::CMD_LOAD,   R8,  R0, 16'h8001, 1'b0, 16'h0000, 4'b0000);
    add_row(alurf_pkg::CMD_LSHIFT, R8,  R0, 16'h0000, 1'b0, 16'h0000, 4'b0000);
    add_row(alurf_pkg::CMD_RSHIFT, R8,  R0, 16'h0000, 1'b0, 16'h0000, 4'b0000);
    // Spare codes behave as a read
    add_row(CMD_SPARE_HI, R5,  R0,  16'hFFFF, 1'b0, 16'h0000, 4'b0000);
    add_row(CMD_SPARE_LO, R15, R15, 16'h5A5A, 1'b0, 16'h0000, 4'b0000);

    // Hold reset, then release it on a falling edge
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_tbl[i]) begin
      pace_sender();
      send_beat(directed_tbl[i].beat, directed_tbl[i].fixed, directed_tbl[i].want);
    end

    // Random beats: mostly ALU work on registers that loads keep refilling
    for (i = 0; i < RANDOM_BEATS; i++) begin
      b.command    = pick_cmd();
      b.dest       = pick_reg();
      b.src        = pick_reg();
      b.load_value = pick_word();
      pace_sender();
      send_beat(b, 1'b0, '0);
    end

    // Drop valid, drain outstanding results, then watch for strays
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (expected_res_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d directed and %0d random command beats; %0d results checked.",
             directed_tbl.size(), RANDOM_BEATS, results_checked);
    $display("Mismatches: %0d", mismatch_count);
    if (mismatch_count == 0) begin
      $display("alu_register_file_with_flags test passed");
    end else begin
      $display("alu_register_file_with_flags test failed");
    end
    $finish;
  end

endmodule

FILE: alu_register_file_with_flags.f
sv/alurf_pkg.sv
sv/alurf_regfile.sv
sv/alurf_alu.sv
sv/alu_register_file_with_flags.sv
sv/alurf_checker.sv
sim/tb_alu_register_file_with_flags.sv
